### rtl/uart_pkg.sv
// Shared types, constants and the bit-timing counter step for the UART transceiver.
package uart_pkg;

    typedef struct packed {
        logic       rx_line;
        logic       send_valid;
        logic [7:0] send_byte;
    } in_t;

    typedef struct packed {
        logic       tx_line;
        logic       tx_busy;
        logic       rx_valid;
        logic [7:0] rx_byte;
        logic       rx_timeout;
    } out_t;

    typedef enum logic [3:0] {
        PH_IDLE  = 4'b0001,
        PH_START = 4'b0010,
        PH_DATA  = 4'b0100,
        PH_STOP  = 4'b1000
    } phase_t;

    typedef struct packed {
        logic        done;
        logic [15:0] count;
    } wait_t;

    typedef struct packed {
        logic       rx_valid;
        logic [7:0] rx_byte;
        logic       rx_timeout;
    } rx_status_t;

    typedef struct packed {
        logic tx_line;
        logic tx_busy;
    } tx_status_t;

    localparam logic [7:0]  CFG_BIT_PERIOD   = 8'd0;
    localparam logic [7:0]  CFG_IDLE_TIMEOUT = 8'd1;
    localparam logic [15:0] BIT_PERIOD_RST   = 16'd16;
    localparam logic [31:0] IDLE_TIMEOUT_RST = 32'd10000;
    localparam logic [2:0]  LAST_BIT         = 3'd7;

    function automatic wait_t wait_step(input logic [15:0] count, input logic [15:0] len);
        logic [15:0] lim;
        logic [16:0] inc;
        wait_t       r;
        lim     = (len == 16'd0) ? 16'd1 : len;
        inc     = {1'b0, count} + 17'd1;
        r.done  = (inc >= {1'b0, lim});
        r.count = r.done ? 16'd0 : inc[15:0];
        return r;
    endfunction

endpackage

### rtl/uart_rx.sv
// Receiver: start detect, mid-bit sampling, stop wait and idle-line timeout.
module uart_rx import uart_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        step,
    input  logic        rx_line,
    input  logic [15:0] bit_period,
    input  logic [31:0] idle_timeout,
    output rx_status_t  status
);

    phase_t      phase_reg, phase_next;
    logic [15:0] tick_reg, tick_next;
    logic [2:0]  bit_reg, bit_next;
    logic [7:0]  shift_reg, shift_next;
    logic [31:0] idle_reg, idle_next;

    logic [31:0] idle_lim;
    logic [32:0] idle_inc;
    logic [15:0] wait_len;
    logic [7:0]  sample;
    wait_t       wt;

    always_comb begin
        idle_lim = (idle_timeout == 32'd0) ? 32'd1 : idle_timeout;
        idle_inc = {1'b0, idle_reg} + 33'd1;
        wait_len = (phase_reg == PH_START) ? {1'b0, bit_period[15:1]} : bit_period;
        wt       = wait_step(tick_reg, wait_len);
        sample   = shift_reg | ({7'd0, rx_line} << bit_reg);

        phase_next = phase_reg;
        tick_next  = tick_reg;
        bit_next   = bit_reg;
        shift_next = shift_reg;
        idle_next  = 32'd0;
        status     = '0;

        unique case (phase_reg)
            PH_IDLE: begin
                if (!rx_line) begin
                    phase_next = PH_START;
                    tick_next  = 16'd0;
                end else if (idle_inc >= {1'b0, idle_lim}) begin
                    status.rx_timeout = 1'b1;
                end else begin
                    idle_next = idle_inc[31:0];
                end
            end
            PH_START: begin
                tick_next = wt.count;
                if (wt.done) begin
                    phase_next = PH_DATA;
                    bit_next   = 3'd0;
                    shift_next = 8'd0;
                end
            end
            PH_DATA: begin
                tick_next = wt.count;
                if (wt.done) begin
                    shift_next = sample;
                    if (bit_reg == LAST_BIT) begin
                        status.rx_valid = 1'b1;
                        status.rx_byte  = sample;
                        phase_next      = PH_STOP;
                        bit_next        = 3'd0;
                    end else begin
                        bit_next = bit_reg + 3'd1;
                    end
                end
            end
            PH_STOP: begin
                if (rx_line) begin
                    phase_next = PH_IDLE;
                end
            end
            default: begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            tick_reg  <= 16'd0;
            bit_reg   <= 3'd0;
            shift_reg <= 8'd0;
            idle_reg  <= 32'd0;
        end else if (step) begin
            phase_reg <= phase_next;
            tick_reg  <= tick_next;
            bit_reg   <= bit_next;
            shift_reg <= shift_next;
            idle_reg  <= idle_next;
        end
    end

endmodule

### rtl/uart_tx.sv
// Transmitter: start bit, eight data bits and stop bit, each one bit period long.
module uart_tx import uart_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        step,
    input  logic        send_valid,
    input  logic [7:0]  send_byte,
    input  logic [15:0] bit_period,
    output tx_status_t  status
);

    phase_t      phase_reg, phase_next;
    logic [15:0] tick_reg, tick_next;
    logic [2:0]  bit_reg, bit_next;
    logic [7:0]  shift_reg, shift_next;
    wait_t       wt;

    always_comb begin
        wt         = wait_step(tick_reg, bit_period);
        phase_next = phase_reg;
        tick_next  = tick_reg;
        bit_next   = bit_reg;
        shift_next = shift_reg;

        unique case (phase_reg)
            PH_IDLE: begin
                if (send_valid) begin
                    shift_next = send_byte;
                    phase_next = PH_START;
                    tick_next  = 16'd0;
                    bit_next   = 3'd0;
                end
            end
            PH_START: begin
                tick_next = wt.count;
                if (wt.done) begin
                    phase_next = PH_DATA;
                    bit_next   = 3'd0;
                end
            end
            PH_DATA: begin
                tick_next = wt.count;
                if (wt.done) begin
                    if (bit_reg == LAST_BIT) begin
                        phase_next = PH_STOP;
                        bit_next   = 3'd0;
                    end else begin
                        bit_next = bit_reg + 3'd1;
                    end
                end
            end
            PH_STOP: begin
                tick_next = wt.count;
                if (wt.done) begin
                    phase_next = PH_IDLE;
                end
            end
            default: begin
                phase_next = PH_IDLE;
            end
        endcase

        unique case (phase_next)
            PH_START: status.tx_line = 1'b0;
            PH_DATA:  status.tx_line = shift_next[bit_next];
            default:  status.tx_line = 1'b1;
        endcase
        status.tx_busy = (phase_next != PH_IDLE);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            tick_reg  <= 16'd0;
            bit_reg   <= 3'd0;
            shift_reg <= 8'd0;
        end else if (step) begin
            phase_reg <= phase_next;
            tick_reg  <= tick_next;
            bit_reg   <= bit_next;
            shift_reg <= shift_next;
        end
    end

endmodule

### rtl/uart_8n1_transceiver.sv
// Top level of the 8N1 UART transceiver: input stage, configuration registers, result stage.
//
//   channel  direction  handshake              payload
//   s_       in         s_valid / s_ready      s_data   (in_t, one clock tick of line data)
//   m_       out        m_valid / m_ready      m_data   (out_t, line and status for that tick)
//   cfg_     in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One transaction per cycle without a stall: input register, one pass of the receiver
// and transmitter logic, result register. m_valid rises when a transaction moves on.
// Reset is synchronous on aresetn; both line engines return to idle, the valid and
// configuration registers take their reset values. A stall on m_ready holds the
// result and input registers; bit timing advances only when a transaction moves on.
module uart_8n1_transceiver import uart_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  in_t         s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output out_t        m_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    logic        in_valid_reg;
    in_t         in_data_reg;
    logic        m_valid_reg;
    out_t        m_data_reg;
    logic [15:0] bit_period_reg;
    logic [31:0] idle_timeout_reg;

    logic       out_free;
    logic       advance;
    rx_status_t rx_stat;
    tx_status_t tx_stat;
    out_t       m_data_next;

    assign out_free  = !m_valid_reg || m_ready;
    assign advance   = in_valid_reg && out_free;
    assign s_ready   = !in_valid_reg || out_free;
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    uart_rx u_rx (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .step         (advance),
        .rx_line      (in_data_reg.rx_line),
        .bit_period   (bit_period_reg),
        .idle_timeout (idle_timeout_reg),
        .status       (rx_stat)
    );

    uart_tx u_tx (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step       (advance),
        .send_valid (in_data_reg.send_valid),
        .send_byte  (in_data_reg.send_byte),
        .bit_period (bit_period_reg),
        .status     (tx_stat)
    );

    always_comb begin
        m_data_next.tx_line    = tx_stat.tx_line;
        m_data_next.tx_busy    = tx_stat.tx_busy;
        m_data_next.rx_valid   = rx_stat.rx_valid;
        m_data_next.rx_byte    = rx_stat.rx_byte;
        m_data_next.rx_timeout = rx_stat.rx_timeout;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bit_period_reg   <= BIT_PERIOD_RST;
            idle_timeout_reg <= IDLE_TIMEOUT_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_BIT_PERIOD:   bit_period_reg   <= cfg_data[15:0];
                CFG_IDLE_TIMEOUT: idle_timeout_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
        if (advance) begin
            m_data_reg <= m_data_next;
        end
    end

    a_idle_line_high: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.tx_busy |-> m_data.tx_line)
        else $error("tx_line low while transmitter idle");

    a_rx_flags_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_data.rx_valid && m_data.rx_timeout))
        else $error("rx_valid and rx_timeout in one transaction");

    a_rx_byte_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.rx_valid |-> m_data.rx_byte == 8'd0)
        else $error("rx_byte nonzero without rx_valid");

    a_stall_holds_input: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !out_free |=> in_valid_reg && $stable(in_data_reg))
        else $error("input register changed during a stall");

endmodule
